>>> src/rcw_pkg.sv
// rcw_pkg: shared types and constants of the reno congestion window keeper
// operation and phase codes, config register indexes, controller command/status structs
// no dependencies
package rcw_pkg;

	// operation carried in the input word's tuser
	typedef enum logic [1:0] {
		OP_NEW     = 2'd0,
		OP_DUP     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	// congestion control phase
	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_REC   = 2'd2
	} phase_t;

	// config register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// config reset values
	localparam logic [15:0] SEG_RESET = 16'd1460;
	localparam logic [10:0] WIN_RESET = 11'd1;
	localparam logic [15:0] THR_RESET = 16'd64;

	// duplicate ack count that fires fast retransmit
	localparam logic [1:0] DUP_TRIGGER = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic init_win;
		logic init_thr;
		logic init_fin;
		logic exec;
		logic prep;
		logic loop_step;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cfg_hit;
		logic need_avoid;
		logic phase_avoid;
		logic loop_done;
		logic out_free;
	} sts_t;

	// 32-bit add that saturates at all ones
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

>>> src/rcw_ctrl.sv
// rcw_ctrl: sequencing state machine of the reno congestion window keeper
// drives datapath commands from datapath status; uses rcw_pkg
module rcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  rcw_pkg::sts_t sts,
	output rcw_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_INIT_W,
		S_INIT_T,
		S_INIT_P,
		S_IDLE,
		S_EXEC,
		S_PREP,
		S_LOOP,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_W;
			ready_q <= 1'b0;
		end else if (sts.cfg_hit) begin
			// a write to the seg, win or thr register index reloads the whole state
			state_q <= S_INIT_W;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT_W: state_q <= S_INIT_T;
				S_INIT_T: state_q <= S_INIT_P;
				S_INIT_P: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
				S_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: state_q <= sts.need_avoid ? S_PREP : S_RESULT;
				S_PREP: state_q <= sts.phase_avoid ? S_LOOP : S_RESULT;
				S_LOOP: begin
					if (sts.loop_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_INIT_W;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	always_comb begin
		cmd           = '0;
		cmd.load_item = s_tvalid && ready_q;
		cmd.init_win  = (state_q == S_INIT_W);
		cmd.init_thr  = (state_q == S_INIT_T);
		cmd.init_fin  = (state_q == S_INIT_P);
		cmd.exec      = (state_q == S_EXEC);
		cmd.prep      = (state_q == S_PREP);
		cmd.loop_step = (state_q == S_LOOP);
		cmd.load_out  = (state_q == S_RESULT) && sts.out_free;
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_item, cmd.init_win, cmd.init_thr, cmd.init_fin,
			cmd.exec, cmd.prep, cmd.loop_step, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_item && !sts.cfg_hit) |=> cmd.exec)
		else $error("accepted word not executed next cycle");

endmodule

>>> src/rcw_datapath.sv
// rcw_datapath: config registers, window state, avoidance loop and result register
// executes commands from rcw_ctrl and reports status; uses rcw_pkg
module rcw_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcw_pkg::cmd_t                   cmd,
	output rcw_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [rcw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [95:0]                     s_tdata,
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [95:0]                     m_tdata,
	output logic [2:0]                      m_tuser
);

	// config registers
	logic [15:0] seg_q;
	logic [10:0] win_seg_q;
	logic [15:0] thr_seg_q;

	// congestion state
	logic [31:0]      window_q;
	logic [31:0]      threshold_q;
	rcw_pkg::phase_t  phase_q;
	logic [1:0]       dup_q;
	logic [31:0]      avoid_q;
	logic             rtx_q;
	logic             m_valid_q;

	// item and loop registers
	rcw_pkg::op_t op_q;
	logic [31:0]  acked_q;
	logic [31:0]  flight_q;
	logic [31:0]  adv_q;
	logic [32:0]  acc_q;
	logic [31:0]  w_q;

	// result word
	logic [31:0] out_allow_q;
	logic [31:0] out_win_q;
	logic [31:0] out_thr_q;
	logic [1:0]  out_phase_q;
	logic        out_rtx_q;

	// zero config values count as one
	logic [15:0] seg_eff;
	logic [10:0] win_eff;
	logic [15:0] thr_eff;
	logic [15:0] mul_b;
	logic [31:0] product;
	logic [31:0] seg32;
	logic [31:0] seg3;
	logic [31:0] half;
	logic [31:0] floor2;
	logic [31:0] reduced;
	logic [1:0]  dup_next;
	logic        below;
	logic [31:0] room;
	logic [31:0] grow;
	logic        reach;
	logic [31:0] usable;
	logic [31:0] allow;

	assign seg_eff = (seg_q == 16'd0) ? 16'd1 : seg_q;
	assign win_eff = (win_seg_q == 11'd0) ? 11'd1 : win_seg_q;
	assign thr_eff = (thr_seg_q == 16'd0) ? 16'd1 : thr_seg_q;

	// one shared multiplier for both reset products
	assign mul_b   = cmd.init_win ? {5'd0, win_eff} : thr_eff;
	assign product = {16'd0, seg_eff} * {16'd0, mul_b};

	assign seg32   = {16'd0, seg_eff};
	assign seg3    = {15'd0, seg_eff, 1'b0} + seg32;
	assign half    = {1'b0, flight_q[31:1]};
	assign floor2  = {15'd0, seg_eff, 1'b0};
	assign reduced = (half > floor2) ? half : floor2;

	assign dup_next = (dup_q == rcw_pkg::DUP_TRIGGER) ? dup_q : dup_q + 2'd1;

	// slow start growth toward the threshold
	assign below = window_q < threshold_q;
	assign room  = below ? threshold_q - window_q : 32'd0;
	assign grow  = (acked_q < room) ? acked_q : room;
	assign reach = !below || (acked_q >= room);

	assign usable = (adv_q < window_q) ? adv_q : window_q;
	assign allow  = (usable > flight_q) ? usable - flight_q : 32'd0;

	always_comb begin
		sts             = '0;
		sts.cfg_hit     = cfg_we && ((cfg_index == rcw_pkg::CFG_SEG) ||
			(cfg_index == rcw_pkg::CFG_WIN) || (cfg_index == rcw_pkg::CFG_THR));
		sts.need_avoid  = (op_q == rcw_pkg::OP_NEW) && (phase_q != rcw_pkg::PH_REC) &&
			(acked_q != 32'd0);
		sts.phase_avoid = (phase_q == rcw_pkg::PH_AVOID);
		sts.loop_done   = acc_q < {1'b0, w_q};
		sts.out_free    = !m_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= rcw_pkg::SEG_RESET;
			win_seg_q   <= rcw_pkg::WIN_RESET;
			thr_seg_q   <= rcw_pkg::THR_RESET;
			window_q    <= '0;
			threshold_q <= '0;
			phase_q     <= rcw_pkg::PH_SLOW;
			dup_q       <= '0;
			avoid_q     <= '0;
			rtx_q       <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rcw_pkg::CFG_SEG: seg_q <= cfg_data;
					rcw_pkg::CFG_WIN: win_seg_q <= cfg_data[10:0];
					rcw_pkg::CFG_THR: thr_seg_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.init_win) begin
				window_q <= product;
			end
			if (cmd.init_thr) begin
				threshold_q <= product;
			end
			if (cmd.init_fin) begin
				phase_q <= (window_q >= threshold_q) ? rcw_pkg::PH_AVOID : rcw_pkg::PH_SLOW;
				dup_q   <= '0;
				avoid_q <= '0;
			end
			if (cmd.load_item) begin
				rtx_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (op_q)
					rcw_pkg::OP_NEW: begin
						dup_q <= '0;
						if (phase_q == rcw_pkg::PH_REC) begin
							window_q <= threshold_q;
							avoid_q  <= '0;
							phase_q  <= rcw_pkg::PH_AVOID;
						end else if (acked_q != 32'd0 && phase_q == rcw_pkg::PH_SLOW) begin
							window_q <= window_q + grow;
							if (reach) begin
								phase_q <= rcw_pkg::PH_AVOID;
							end
						end
					end
					rcw_pkg::OP_DUP: begin
						dup_q <= dup_next;
						if (phase_q == rcw_pkg::PH_REC) begin
							window_q <= rcw_pkg::sat_add(window_q, seg32);
						end else if (dup_next == rcw_pkg::DUP_TRIGGER) begin
							threshold_q <= reduced;
							window_q    <= rcw_pkg::sat_add(reduced, seg3);
							avoid_q     <= '0;
							phase_q     <= rcw_pkg::PH_REC;
							rtx_q       <= 1'b1;
						end
					end
					rcw_pkg::OP_TIMEOUT: begin
						threshold_q <= reduced;
						window_q    <= seg32;
						avoid_q     <= '0;
						dup_q       <= '0;
						phase_q     <= rcw_pkg::PH_SLOW;
					end
					default: ;
				endcase
			end
			if (cmd.loop_step && sts.loop_done) begin
				window_q <= w_q;
				avoid_q  <= acc_q[31:0];
			end
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= rcw_pkg::op_t'(s_tuser);
			acked_q  <= s_tdata[31:0];
			flight_q <= s_tdata[63:32];
			adv_q    <= s_tdata[95:64];
		end
		if (cmd.exec && op_q == rcw_pkg::OP_NEW && phase_q == rcw_pkg::PH_SLOW) begin
			acked_q <= acked_q - grow;
		end
		if (cmd.prep) begin
			acc_q <= {1'b0, avoid_q} + {1'b0, acked_q};
			w_q   <= (window_q == 32'd0) ? 32'd1 : window_q;
		end
		// one subtract-and-grow step per cycle
		if (cmd.loop_step && !sts.loop_done) begin
			acc_q <= acc_q - {1'b0, w_q};
			w_q   <= rcw_pkg::sat_add(w_q, seg32);
		end
		if (cmd.load_out) begin
			out_allow_q <= allow;
			out_win_q   <= window_q;
			out_thr_q   <= threshold_q;
			out_phase_q <= phase_q;
			out_rtx_q   <= rtx_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_thr_q, out_win_q, out_allow_q};
	assign m_tuser  = {out_phase_q, out_rtx_q};

	a_avoid_below: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.loop_step && sts.loop_done) |=> (avoid_q < window_q))
		else $error("avoidance remainder not below window");

	a_rtx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_rtx_q) |-> (out_phase_q == rcw_pkg::PH_REC))
		else $error("fast retransmit outside fast recovery");

	a_timeout_win: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == rcw_pkg::OP_TIMEOUT) |=> (window_q == {16'd0, $past(seg_eff)}))
		else $error("timeout did not collapse window to one segment");

endmodule

>>> src/reno_congestion_window.sv
// reno_congestion_window: tcp reno congestion window keeper, stream in and stream out
// an accepted word passes the execute and result states; a new ack with bytes outside
//   fast recovery adds a prep state, then one-segment avoidance loop steps when it ends in avoidance
// a new word is taken only after the last word's result is loaded into the output register;
//   a result word held by the receiver stalls the next finished word, and the input behind it
// reset and every write to the seg, win or thr index reload the state in an init pass, tready held low
module reno_congestion_window (
	input  logic                            clk,
	input  logic                            arst_n,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [95:0]                     s_tdata,   // acked bytes, bytes in flight, receiver window
	input  logic [1:0]                      s_tuser,   // operation
	// result words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [95:0]                     m_tdata,   // sendable bytes, window_bytes, threshold_bytes
	output logic [2:0]                      m_tuser,   // retransmit_now, phase
	// config write port
	input  logic                            cfg_we,
	input  logic [rcw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// command and status between sequencer and datapath
	rcw_pkg::cmd_t cmd;
	rcw_pkg::sts_t sts;

	// sequencer: init pass, accept, execute, avoidance loop, result load
	rcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: config, window state, subtract-and-grow loop, output register
	// the output register lets the next word be taken while a result waits
	rcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for reno_congestion_window, stream in, stream out, config port
// keeps its own congestion window predictor and compares every result word field by field
// depends on rcw_pkg and reno_congestion_window
module testbench;

	// unused register index, writes to it change nothing
	localparam logic [rcw_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// most avoidance steps one random new ack may cost the block
	localparam int unsigned STEP_BUDGET = 200;
	// hard stop, several times the slowest legal run
	localparam int RUN_LIMIT = 80_000_000;

	// predictor state: register copies plus congestion state
	typedef struct packed {
		logic [15:0]     seg_reg;
		logic [10:0]     win_reg;
		logic [15:0]     thr_reg;
		logic [31:0]     window;
		logic [31:0]     threshold;
		logic [31:0]     avoid;
		rcw_pkg::phase_t phase;
		logic [1:0]      dups;
	} cwnd_state_t;

	// one result word as the predictor sees it
	typedef struct packed {
		logic            rtx;
		logic [31:0]     allowance;
		logic [31:0]     window;
		logic [31:0]     threshold;
		rcw_pkg::phase_t phase;
	} cwnd_word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;   // acked bytes, bytes in flight, receiver window
	logic [1:0] s_tuser;    // operation
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;   // sendable bytes, window_bytes, threshold_bytes
	logic [2:0] m_tuser;    // retransmit_now, phase
	logic cfg_we;
	logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rcw_pkg::CFG_DATA_W-1:0] cfg_data;

	cwnd_state_t cwnd_model;
	cwnd_word_t awaited_words[$];
	cwnd_word_t due;
	int unsigned events_sent = 0;
	int unsigned words_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holdoff_left = 0;

	reno_congestion_window DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// a zero segment size counts as one byte
	function automatic logic [31:0] eff_seg(input cwnd_state_t st);
		return (st.seg_reg == 16'd0) ? 32'd1 : {16'd0, st.seg_reg};
	endfunction

	// window growth clips at all ones instead of wrapping
	function automatic logic [31:0] grow_clipped(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// threshold after a loss: half the flight, never under two segments
	function automatic logic [31:0] cut_threshold(input logic [31:0] flight,
			input logic [31:0] seg);
		logic [31:0] half;
		logic [31:0] floor2;
		half = flight >> 1;
		floor2 = seg << 1;
		return (half > floor2) ? half : floor2;
	endfunction

	// initial window and threshold from the registers, zero counts as one
	function automatic void reload_window(inout cwnd_state_t st);
		logic [31:0] seg;
		logic [31:0] wsegs;
		logic [31:0] tsegs;
		seg = eff_seg(st);
		wsegs = (st.win_reg == 11'd0) ? 32'd1 : {21'd0, st.win_reg};
		tsegs = (st.thr_reg == 16'd0) ? 32'd1 : {16'd0, st.thr_reg};
		st.window = seg * wsegs;
		st.threshold = seg * tsegs;
		st.phase = (st.window >= st.threshold) ? rcw_pkg::PH_AVOID : rcw_pkg::PH_SLOW;
		st.dups = 2'd0;
		st.avoid = 32'd0;
	endfunction

	// applies one event to the state and builds its result word;
	// returns how many one-segment avoidance steps the new ack earned
	function automatic int unsigned advance_window(inout cwnd_state_t st,
			input rcw_pkg::op_t op, input logic [31:0] acked, input logic [31:0] flight,
			input logic [31:0] adv, output cwnd_word_t res);
		logic [31:0] seg;
		logic [31:0] room;
		logic [31:0] grow;
		logic [31:0] usable;
		logic [63:0] acc;
		int unsigned steps;
		seg = eff_seg(st);
		steps = 0;
		res.rtx = 1'b0;
		case (op)
			rcw_pkg::OP_NEW: begin
				st.dups = 2'd0;
				if (st.phase == rcw_pkg::PH_REC) begin
					// deflate to the threshold, recovery over
					st.window = st.threshold;
					st.avoid = 32'd0;
					st.phase = rcw_pkg::PH_AVOID;
				end else if (acked != 32'd0) begin
					if (st.phase == rcw_pkg::PH_SLOW) begin
						room = (st.window < st.threshold) ? st.threshold - st.window : 32'd0;
						grow = (acked < room) ? acked : room;
						st.window += grow;
						acked -= grow;
						if (st.window >= st.threshold)
							st.phase = rcw_pkg::PH_AVOID;
					end
					if (st.phase == rcw_pkg::PH_AVOID) begin
						// one segment for each full window of acked bytes
						acc = {32'd0, st.avoid} + {32'd0, acked};
						if (st.window == 32'd0)
							st.window = 32'd1;
						while (acc >= {32'd0, st.window}) begin
							acc -= {32'd0, st.window};
							st.window = grow_clipped(st.window, seg);
							steps++;
						end
						st.avoid = acc[31:0];
					end
				end
			end
			rcw_pkg::OP_DUP: begin
				if (st.dups < rcw_pkg::DUP_TRIGGER)
					st.dups++;
				if (st.phase == rcw_pkg::PH_REC) begin
					st.window = grow_clipped(st.window, seg);
				end else if (st.dups == rcw_pkg::DUP_TRIGGER) begin
					// fast retransmit, enter recovery
					st.threshold = cut_threshold(flight, seg);
					st.window = grow_clipped(st.threshold,
						{30'd0, rcw_pkg::DUP_TRIGGER} * seg);
					st.avoid = 32'd0;
					st.phase = rcw_pkg::PH_REC;
					res.rtx = 1'b1;
				end
			end
			rcw_pkg::OP_TIMEOUT: begin
				st.threshold = cut_threshold(flight, seg);
				st.window = seg;
				st.avoid = 32'd0;
				st.dups = 2'd0;
				st.phase = rcw_pkg::PH_SLOW;
			end
			default: ;
		endcase
		usable = (adv < st.window) ? adv : st.window;
		res.allowance = (usable > flight) ? usable - flight : 32'd0;
		res.window = st.window;
		res.threshold = st.threshold;
		res.phase = st.phase;
		return steps;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch: %s", msg);
	endtask

	// every accepted result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (awaited_words.size() == 0) begin
				note_mismatch($sformatf("word %0d came with nothing expected", words_seen));
			end else begin
				due = awaited_words.pop_front();
				if (m_tuser[0] !== due.rtx)
					note_mismatch($sformatf("word %0d retransmit_now %b, want %b",
						words_seen, m_tuser[0], due.rtx));
				if (m_tdata[31:0] !== due.allowance)
					note_mismatch($sformatf("word %0d sendable bytes %h, want %h",
						words_seen, m_tdata[31:0], due.allowance));
				if (m_tdata[63:32] !== due.window)
					note_mismatch($sformatf("word %0d window_bytes %h, want %h",
						words_seen, m_tdata[63:32], due.window));
				if (m_tdata[95:64] !== due.threshold)
					note_mismatch($sformatf("word %0d threshold_bytes %h, want %h",
						words_seen, m_tdata[95:64], due.threshold));
				if (m_tuser[2:1] !== due.phase)
					note_mismatch($sformatf("word %0d phase %0d, want %0d",
						words_seen, m_tuser[2:1], due.phase));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// random stalls, or a long counted hold-off when one is requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left != 0) begin
				m_tready <= 1'b0;
				holdoff_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offers one word, waits for the handshake, then predicts its result;
	// tvalid stays high for a following word unless an idle gap comes first
	task automatic send_event(input rcw_pkg::op_t op, input logic [31:0] acked,
			input logic [31:0] flight, input logic [31:0] adv);
		cwnd_word_t word;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {adv, flight, acked};
		do @(posedge clk); while (!s_tready);
		void'(advance_window(cwnd_model, op, acked, flight, adv, word));
		awaited_words.push_back(word);
		events_sent++;
	endtask

	// drop tvalid and wait for every expected word
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_words.size() != 0)
			@(negedge clk);
	endtask

	// register write only with the block drained, then the predictor follows
	task automatic write_register(input logic [rcw_pkg::CFG_IDX_W-1:0] idx,
			input logic [rcw_pkg::CFG_DATA_W-1:0] value);
		settle();
		// let the last word's pipeline and any init pass finish
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rcw_pkg::CFG_SEG: cwnd_model.seg_reg = value;
			rcw_pkg::CFG_WIN: cwnd_model.win_reg = value[10:0];
			rcw_pkg::CFG_THR: cwnd_model.thr_reg = value;
			default: return;
		endcase
		reload_window(cwnd_model);
	endtask

	// random fields scaled to the current window; a new ack that would
	// cost too many avoidance steps gets its byte count cut down
	task automatic offer_event(input rcw_pkg::op_t op);
		logic [31:0] acked;
		logic [31:0] flight;
		logic [31:0] adv;
		logic [31:0] cap;
		cwnd_state_t probe;
		cwnd_word_t scratch;
		cap = (cwnd_model.window > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : cwnd_model.window << 2;
		case ($urandom_range(9))
			0: acked = 32'd0;
			1, 2: acked = $urandom_range(eff_seg(cwnd_model), 1);
			3, 4: acked = $urandom_range(cwnd_model.window);
			5, 6: acked = $urandom_range(cap);
			default: acked = $urandom();
		endcase
		case ($urandom_range(7))
			0: flight = 32'd0;
			1: flight = 32'hFFFF_FFFF;
			2, 3: flight = $urandom_range(cwnd_model.window);
			4, 5: flight = $urandom_range(cap);
			default: flight = $urandom();
		endcase
		case ($urandom_range(7))
			0: adv = 32'd0;
			1: adv = 32'hFFFF_FFFF;
			2, 3: adv = $urandom_range(cap);
			4: adv = $urandom_range(cwnd_model.window);
			default: adv = $urandom();
		endcase
		probe = cwnd_model;
		while (advance_window(probe, op, acked, flight, adv, scratch) > STEP_BUDGET) begin
			acked = acked >> 2;
			probe = cwnd_model;
		end
		send_event(op, acked, flight, adv);
	endtask

	// mostly realistic ack patterns, the rest single random words
	task automatic run_scenario();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// plain growth
			repeat ($urandom_range(8, 1)) offer_event(rcw_pkg::OP_NEW);
		end else if (pick < 68) begin
			// loss: enough dups for fast retransmit, inflation, then recovery exit
			repeat ($urandom_range(7, 3)) offer_event(rcw_pkg::OP_DUP);
			repeat ($urandom_range(2, 1)) offer_event(rcw_pkg::OP_NEW);
		end else if (pick < 76) begin
			// timeout and slow start restart
			offer_event(rcw_pkg::OP_TIMEOUT);
			repeat ($urandom_range(5, 1)) offer_event(rcw_pkg::OP_NEW);
		end else if (pick < 86) begin
			// reordering: a dup or two and a new ack, mostly without a retransmit
			repeat ($urandom_range(2, 1)) offer_event(rcw_pkg::OP_DUP);
			offer_event(rcw_pkg::OP_NEW);
		end else begin
			offer_event(rcw_pkg::op_t'($urandom_range(3)));
		end
	endtask

	// random register setting, extremes weighted in
	task automatic pick_random_setting();
		logic [15:0] seg_val;
		logic [10:0] win_val;
		logic [15:0] thr_val;
		logic [4:0] pad;
		logic [15:0] junk;
		case ($urandom_range(5))
			0: seg_val = 16'd0;
			1: seg_val = 16'hFFFF;
			2: seg_val = 16'd1460;
			3: seg_val = 16'd536;
			default: seg_val = 16'($urandom());
		endcase
		case ($urandom_range(4))
			0: win_val = 11'd0;
			1: win_val = 11'h7FF;
			2: win_val = 11'd1;
			default: win_val = 11'($urandom());
		endcase
		case ($urandom_range(4))
			0: thr_val = 16'd0;
			1: thr_val = 16'hFFFF;
			2: thr_val = 16'd64;
			default: thr_val = 16'($urandom());
		endcase
		// upper bits of the window register write are don't care
		pad = 5'($urandom());
		junk = 16'($urandom());
		write_register(rcw_pkg::CFG_SEG, seg_val);
		write_register(rcw_pkg::CFG_WIN, {pad, win_val});
		write_register(rcw_pkg::CFG_THR, thr_val);
		if ($urandom_range(3) == 0)
			write_register(CFG_SPARE, junk);
	endtask

	// ---------------------------------------------------------------- tests

	// reset defaults: every operation, field extremes, loss and recovery paths
	task automatic test_directed_events();
		send_idle_pct = 35;
		recv_stall_pct = 58;
		send_event(rcw_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0);
		send_event(rcw_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_QUERY, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// new ack with nothing acked
		send_event(rcw_pkg::OP_NEW, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'd2920, 32'd4380, 32'hFFFF_FFFF);
		// crosses the threshold, remainder goes to avoidance
		send_event(rcw_pkg::OP_NEW, 32'd200000, 32'd10000, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'd100000, 32'd20000, 32'd50000);
		// third dup fires fast retransmit
		repeat (3) send_event(rcw_pkg::OP_DUP, 32'd0, 32'd100000, 32'hFFFF_FFFF);
		repeat (2) send_event(rcw_pkg::OP_DUP, 32'd0, 32'd100000, 32'd30000);
		send_event(rcw_pkg::OP_NEW, 32'd1000, 32'd50000, 32'hFFFF_FFFF);
		// small flight, threshold held at two segments
		repeat (3) send_event(rcw_pkg::OP_DUP, 32'd0, 32'd1000, 32'hFFFF_FFFF);
		// zero-byte new ack still ends recovery
		send_event(rcw_pkg::OP_NEW, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_event(rcw_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000);
		settle();
	endtask

	// zero registers, largest registers with window saturation, the unused index
	task automatic test_register_extremes();
		write_register(rcw_pkg::CFG_SEG, 16'd0);
		send_event(rcw_pkg::OP_NEW, 32'd5, 32'd0, 32'hFFFF_FFFF);
		repeat (3) send_event(rcw_pkg::OP_DUP, 32'd0, 32'd10, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_TIMEOUT, 32'd0, 32'd3, 32'hFFFF_FFFF);
		write_register(rcw_pkg::CFG_WIN, 16'd0);
		write_register(rcw_pkg::CFG_THR, 16'd0);
		// window equals threshold, starts in avoidance
		send_event(rcw_pkg::OP_NEW, 32'd1, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'd7, 32'd1, 32'hFFFF_FFFF);
		write_register(rcw_pkg::CFG_SEG, 16'hFFFF);
		write_register(rcw_pkg::CFG_WIN, 16'hFFFF);
		write_register(rcw_pkg::CFG_THR, 16'hFFFF);
		// huge acks drive the window into saturation
		repeat (4) send_event(rcw_pkg::OP_NEW, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		repeat (4) send_event(rcw_pkg::OP_DUP, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_register(CFG_SPARE, 16'h5A5A);
		send_event(rcw_pkg::OP_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF);
		write_register(rcw_pkg::CFG_SEG, 16'd1460);
		write_register(rcw_pkg::CFG_WIN, 16'd1024);
		write_register(rcw_pkg::CFG_THR, 16'd1);
		send_event(rcw_pkg::OP_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_event(rcw_pkg::OP_NEW, 32'd3000, 32'd0, 32'hFFFF_FFFF);
		settle();
	endtask

	// receiver holds off long while the sender keeps offering, input must stall
	task automatic test_receiver_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 58;
		holdoff_left = 400;
		repeat (6) run_scenario();
		settle();
	endtask

	// sender pauses until every expected word has come, then resumes
	task automatic test_sender_pause();
		send_idle_pct = 35;
		recv_stall_pct = 58;
		repeat (3) run_scenario();
		settle();
		repeat (3) run_scenario();
		settle();
	endtask

	// random traffic in bursts, a new register setting before each burst
	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned target;
		int unsigned burst_end;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = events_sent + count;
		while (events_sent < target) begin
			pick_random_setting();
			burst_end = events_sent + $urandom_range(160, 60);
			while (events_sent < burst_end && events_sent < target)
				run_scenario();
		end
		settle();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rcw_pkg::OP_QUERY;
		cfg_we = 1'b0;
		cfg_index = rcw_pkg::CFG_SEG;
		cfg_data = '0;
		cwnd_model = '0;
		cwnd_model.seg_reg = rcw_pkg::SEG_RESET;
		cwnd_model.win_reg = rcw_pkg::WIN_RESET;
		cwnd_model.thr_reg = rcw_pkg::THR_RESET;
		reload_window(cwnd_model);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_register_extremes();
		test_receiver_holdoff();
		test_sender_pause();
		// receiver stalls more than the sender idles, then the reverse, then neither
		test_random_traffic(500, 35, 58);
		test_random_traffic(500, 58, 35);
		test_random_traffic(500, 0, 0);

		// nothing expected any more; watch for stray words a little longer
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("** reno_congestion_window: PASSED **");
		else
			$display("** reno_congestion_window: FAILED **");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#RUN_LIMIT;
		$display("** reno_congestion_window: FAILED **");
		$finish;
	end

endmodule
